/* rtl/core/lce_pkg.sv */
`timescale 1ns / 1ps

package lce_pkg;

  localparam int unsigned IdxW        = 32;
  localparam int unsigned MaxComboDef = 4;
  localparam int unsigned NumSlots    = 4;
  localparam int unsigned PaddrW      = 3;
  localparam int unsigned PdataW      = 32;

  localparam logic REQ_OPEN = 1'b0;
  localparam logic REQ_NEXT = 1'b1;

  localparam logic [0:0] REG_COMBO_SIZE = 1'b0;
  localparam logic [0:0] REG_WITH_REPL  = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [IdxW-1:0] list_start;
    logic [IdxW-1:0] list_stop;
  } lce_in_t;

  typedef struct packed {
    logic [IdxW-1:0] index_a;
    logic [IdxW-1:0] index_b;
    logic [IdxW-1:0] index_c;
    logic [IdxW-1:0] index_d;
    logic [IdxW-1:0] out_position;
    logic            tuple_valid;
    logic            last_of_list;
  } lce_out_t;

  typedef struct packed {
    logic            fill;
    logic [IdxW-1:0] value;
  } lce_fill_t;

endpackage

/* rtl/core/lce_cell.sv */
`timescale 1ns / 1ps

module lce_cell import lce_pkg::*; #(
  parameter int unsigned MaxCombo = MaxComboDef,
  parameter int unsigned CellIdx  = 0,
  localparam int unsigned KW      = $clog2(MaxCombo + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            step_i,
  input  logic [IdxW-1:0] start_i,
  input  logic [IdxW-1:0] stop_i,
  input  logic [KW-1:0]   k_i,
  input  logic            repl_i,
  input  logic            right_found_i,
  input  lce_fill_t       fill_i,
  output logic            found_o,
  output lce_fill_t       fill_o,
  output logic [IdxW-1:0] value_o
);

  logic [IdxW-1:0] value_q, value_d, next_val;
  logic            active, can_inc, pivot;
  logic [IdxW:0]   need;

  assign active = k_i > KW'(CellIdx);
  assign need   = repl_i ? (IdxW+1)'(1) : ((IdxW+1)'(k_i) - (IdxW+1)'(CellIdx));

  assign can_inc = active && (({1'b0, value_q} + need) < {1'b0, stop_i});
  assign pivot   = can_inc & ~right_found_i;
  assign found_o = right_found_i | can_inc;

  always_comb begin
    if (pivot) begin
      next_val = value_q + IdxW'(1);
    end else if (fill_i.fill && active) begin
      next_val = repl_i ? fill_i.value : fill_i.value + IdxW'(1);
    end else begin
      next_val = value_q;
    end
  end

  assign fill_o.fill  = pivot | (fill_i.fill & active);
  assign fill_o.value = next_val;

  always_comb begin
    value_d = value_q;
    if (load_i) begin
      if (active) begin
        value_d = repl_i ? start_i : start_i + IdxW'(CellIdx);
      end else begin
        value_d = '0;
      end
    end else if (step_i) begin
      value_d = next_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

/* rtl/core/lce_skid.sv */
`timescale 1ns / 1ps

module lce_skid import lce_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lce_out_t item_i,
  input  logic     stall_i,
  output logic     full_o,
  output logic     valid_o,
  output lce_out_t item_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  lce_out_t out_q, out_d;
  lce_out_t skid_q, skid_d;
  logic     out_free;

  assign out_free = ~out_valid_q | ~stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = item_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign item_o  = out_q;

endmodule

/* rtl/core/list_combination_enumerator_unit.sv */
`timescale 1ns / 1ps

// Lexicographic tuple generator. An open item loads a list range and the
// configured tuple size. Each next item returns one result: the current
// tuple, stepping to its successor, while one is pending, else no tuple.
// The block takes one item per cycle while in_stall_o is low and registers
// each result; the successor is found by a single pass of compare and fill
// along the row of index cells, one cell per tuple slot. A two-entry output
// buffer keeps input and output apart, so in_stall_o rises only when both
// entries are full. Configuration writes take effect at the next open item.

module list_combination_enumerator_unit import lce_pkg::*; #(
  parameter int unsigned MaxCombo = MaxComboDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lce_in_t           in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lce_out_t          out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned KW = $clog2(MaxCombo + 1);

  logic [2:0]      combo_q, combo_d;
  logic            repl_q, repl_d;
  logic [KW-1:0]   held_k_q, held_k_d;
  logic            held_repl_q, held_repl_d;
  logic [IdxW-1:0] stop_q, stop_d;
  logic            pending_q, pending_d;
  logic [IdxW-1:0] count_q, count_d;

  logic            buf_full, in_acc, open_acc, adv_acc, step, more, cfg_wr;
  logic [3:0]      combo_ext, eff_k;
  logic [0:0]      reg_idx;
  logic            open_pending;
  lce_out_t        res;

  logic [IdxW-1:0] cur [MaxCombo];
  logic [MaxCombo:0] found;
  lce_fill_t       fill [MaxCombo+1];
  logic [IdxW-1:0] slot [NumSlots];

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      REG_COMBO_SIZE: prdata = {{(PdataW-3){1'b0}}, combo_q};
      REG_WITH_REPL:  prdata = {{(PdataW-1){1'b0}}, repl_q};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    combo_d = combo_q;
    repl_d  = repl_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_COMBO_SIZE: combo_d = pwdata[2:0];
        REG_WITH_REPL:  repl_d  = pwdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i & ~buf_full;
  assign open_acc   = in_acc & (in_item_i.req_type == REQ_OPEN);
  assign adv_acc    = in_acc & (in_item_i.req_type == REQ_NEXT);
  assign step       = adv_acc & pending_q;

  always_comb begin
    combo_ext = {1'b0, combo_q};
    if (combo_ext == 4'd0) begin
      eff_k = 4'd1;
    end else if (combo_ext > 4'(MaxCombo)) begin
      eff_k = 4'(MaxCombo);
    end else begin
      eff_k = combo_ext;
    end
  end

  assign open_pending = repl_q
      ? (in_item_i.list_start < in_item_i.list_stop)
      : (({1'b0, in_item_i.list_start} + (IdxW+1)'(eff_k)) <= {1'b0, in_item_i.list_stop});

  assign found[MaxCombo] = 1'b0;
  assign fill[0]         = '0;

  for (genvar j = 0; j < MaxCombo; j++) begin : g_cell
    lce_cell #(
      .MaxCombo(MaxCombo),
      .CellIdx (j)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (open_acc),
      .step_i       (step),
      .start_i      (in_item_i.list_start),
      .stop_i       (open_acc ? in_item_i.list_stop : stop_q),
      .k_i          (open_acc ? KW'(eff_k) : held_k_q),
      .repl_i       (open_acc ? repl_q : held_repl_q),
      .right_found_i(found[j+1]),
      .fill_i       (fill[j]),
      .found_o      (found[j]),
      .fill_o       (fill[j+1]),
      .value_o      (cur[j])
    );
  end

  assign more = found[0];

  for (genvar s = 0; s < NumSlots; s++) begin : g_slot
    if (s < MaxCombo) begin : g_used
      assign slot[s] = cur[s];
    end else begin : g_zero
      assign slot[s] = '0;
    end
  end

  always_comb begin
    res = '0;
    if (pending_q) begin
      res.index_a      = slot[0];
      res.index_b      = slot[1];
      res.index_c      = slot[2];
      res.index_d      = slot[3];
      res.out_position = count_q;
      res.tuple_valid  = 1'b1;
      res.last_of_list = ~more;
    end
  end

  always_comb begin
    held_k_d    = held_k_q;
    held_repl_d = held_repl_q;
    stop_d      = stop_q;
    pending_d   = pending_q;
    count_d     = count_q;
    if (open_acc) begin
      held_k_d    = KW'(eff_k);
      held_repl_d = repl_q;
      stop_d      = in_item_i.list_stop;
      pending_d   = open_pending;
    end else if (step) begin
      pending_d = more;
      count_d   = count_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      combo_q     <= 3'd2;
      repl_q      <= 1'b0;
      held_k_q    <= KW'(1);
      held_repl_q <= 1'b0;
      stop_q      <= '0;
      pending_q   <= 1'b0;
      count_q     <= '0;
    end else begin
      combo_q     <= combo_d;
      repl_q      <= repl_d;
      held_k_q    <= held_k_d;
      held_repl_q <= held_repl_d;
      stop_q      <= stop_d;
      pending_q   <= pending_d;
      count_q     <= count_d;
    end
  end

  lce_skid u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (adv_acc),
    .item_i (res),
    .stall_i(out_stall_i),
    .full_o (buf_full),
    .valid_o(out_valid_o),
    .item_o (out_item_o)
  );

  a_stall_needs_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("Input stalled while the output register is empty.");

  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.tuple_valid) |->
      (!out_item_o.last_of_list && out_item_o.out_position == '0))
    else $error("Result without a tuple carries nonzero fields.");

  a_last_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !more) |=> !pending_q)
    else $error("Tuple still pending after the last tuple of the list.");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> count_q == $past(count_q) + IdxW'(1))
    else $error("Position count did not advance with an emitted tuple.");

endmodule
